// ----- sv/rmt_pkg.sv -----
`timescale 1ns / 1ps

package rmt_pkg;

  // Default sizing of the tracker
  localparam int DEF_MAX_SAMPLES = 256;
  localparam int DEF_SAMPLE_BITS = 16;

  // Cells per group in the first level of the middle-entry select tree
  localparam int SEL_GROUP = 16;

endpackage

// ----- sv/rmt_in_if.sv -----
`timescale 1ns / 1ps

interface rmt_in_if
  import rmt_pkg::*;
#(
  parameter int SW = DEF_SAMPLE_BITS
) ();
  logic                 valid;
  logic                 ready;
  logic signed [SW-1:0] sample;
  logic                 last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

// ----- sv/rmt_out_if.sv -----
`timescale 1ns / 1ps

interface rmt_out_if
  import rmt_pkg::*;
#(
  parameter int MW = DEF_SAMPLE_BITS + 1,
  parameter int CW = $clog2(DEF_MAX_SAMPLES + 1)
) ();
  logic                 valid;
  logic                 ready;
  logic signed [MW-1:0] median_doubled;
  logic        [CW-1:0] stored_count;
  logic                 overflow;

  modport source (output valid, output median_doubled, output stored_count,
                  output overflow, input ready);
  modport sink   (input valid, input median_doubled, input stored_count,
                  input overflow, output ready);
endinterface

// ----- sv/rmt_cell.sv -----
`timescale 1ns / 1ps

// One slot of the sorted chain. On insert it keeps its value, takes the new
// sample, or takes its left neighbor's value, so the chain stays ascending.
module rmt_cell
  import rmt_pkg::*;
#(
  parameter int SW  = DEF_SAMPLE_BITS,
  parameter int CW  = $clog2(DEF_MAX_SAMPLES + 1),
  parameter int IDX = 0
) (
  input  logic                 clk,
  input  logic                 ins,
  input  logic signed [SW-1:0] x,
  input  logic        [CW-1:0] count,
  input  logic signed [SW-1:0] left_v,
  input  logic                 left_keep,
  output logic signed [SW-1:0] v,
  output logic                 keep
);

  logic occupied;

  assign occupied = CW'(IDX) < count;
  // equal entries stay put, so a new sample lands after them
  assign keep     = occupied && (v <= x);

  always_ff @(posedge clk) begin
    if (ins && !keep) begin
      v <= left_keep ? x : left_v;
    end
  end

endmodule

// ----- sv/rmt_sel.sv -----
`timescale 1ns / 1ps

// Picks the two middle entries out of the chain through a registered
// two-level AND-OR tree. Output follows the chain through the group registers, then the output registers.
module rmt_sel
  import rmt_pkg::*;
#(
  parameter int N  = DEF_MAX_SAMPLES,
  parameter int SW = DEF_SAMPLE_BITS,
  parameter int IW = $clog2(DEF_MAX_SAMPLES)
) (
  input  logic                 clk,
  input  logic signed [SW-1:0] vals [N],
  input  logic        [IW-1:0] lo_idx,
  input  logic        [IW-1:0] hi_idx,
  output logic signed [SW-1:0] lo,
  output logic signed [SW-1:0] hi
);

  localparam int NG = (N + SEL_GROUP - 1) / SEL_GROUP;

  logic [SW-1:0] grp_lo [NG];
  logic [SW-1:0] grp_hi [NG];

  for (genvar g = 0; g < NG; g++) begin : g_grp
    localparam int BASE = g * SEL_GROUP;
    localparam int LEN  = (N - BASE < SEL_GROUP) ? N - BASE : SEL_GROUP;
    logic [SW-1:0] acc_lo, acc_hi;

    always_comb begin
      acc_lo = '0;
      acc_hi = '0;
      for (int j = 0; j < LEN; j++) begin
        if (IW'(BASE + j) == lo_idx) acc_lo = acc_lo | vals[BASE + j];
        if (IW'(BASE + j) == hi_idx) acc_hi = acc_hi | vals[BASE + j];
      end
    end

    always_ff @(posedge clk) begin
      grp_lo[g] <= acc_lo;
      grp_hi[g] <= acc_hi;
    end
  end

  logic [SW-1:0] or_lo, or_hi;

  always_comb begin
    or_lo = '0;
    or_hi = '0;
    for (int g = 0; g < NG; g++) begin
      or_lo = or_lo | grp_lo[g];
      or_hi = or_hi | grp_hi[g];
    end
  end

  always_ff @(posedge clk) begin
    lo <= or_lo;
    hi <= or_hi;
  end

endmodule

// ----- sv/running_median_tracker_top.sv -----
`timescale 1ns / 1ps

// Running median tracker.
// samples : one beat per stream sample (sample, last_sample), valid/ready.
// medians : one beat per sample: median_doubled (twice the median of all
//           samples held, exact for half values), stored_count, overflow.
// Samples live in a row of MAX_SAMPLES cells kept in ascending order; a new
// sample is inserted in the cycle it is accepted, every cell deciding from
// one compare whether it keeps, takes the sample or takes its left neighbor.
// The two middle entries then travel through a two-stage registered select
// tree, and a result is registered once the insert, both select stages and
// the output are done; only then is the next sample taken.
// When the store is full the sample is dropped, overflow is set and the
// previous median is repeated. A beat with last_sample empties the store
// once its result is formed.
// Reset (rst, synchronous) empties the store and clears the held median;
// no clearing pass is needed, cells beyond the count are never read.
// If the receiver stalls, the result waits in the output register; one more
// sample is taken and processed, and its result holds until the beat ahead
// of it is taken.
module running_median_tracker_top
  import rmt_pkg::*;
#(
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic             clk,
  input  logic             rst,
  rmt_in_if.sink           samples,
  rmt_out_if.source        medians
);

  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int IW = $clog2(MAX_SAMPLES);
  localparam int MW = SAMPLE_BITS + 1;

  typedef enum logic [1:0] {IDLE, SEL1, SEL2, FIN} state_t;

  state_t               state;
  logic        [CW-1:0] count;
  logic signed [MW-1:0] last_med;
  logic                 last_r;
  logic                 ovf_r;

  logic full, acc, ins, fin_go;

  assign samples.ready = (state == IDLE);
  assign acc    = samples.valid && samples.ready;
  assign full   = (count == CW'(MAX_SAMPLES));
  assign ins    = acc && !full;
  assign fin_go = (state == FIN) && (!medians.valid || medians.ready);

  // sorted chain
  logic signed [SAMPLE_BITS-1:0] vals [MAX_SAMPLES];
  logic                          keep [MAX_SAMPLES];

  for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] lv;
    logic                          lk;
    if (i == 0) begin : g_head
      assign lv = samples.sample;
      assign lk = 1'b1;
    end else begin : g_body
      assign lv = vals[i-1];
      assign lk = keep[i-1];
    end
    rmt_cell #(
      .SW  (SAMPLE_BITS),
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .ins       (ins),
      .x         (samples.sample),
      .count     (count),
      .left_v    (lv),
      .left_keep (lk),
      .v         (vals[i]),
      .keep      (keep[i])
    );
  end

  // middle entries: equal for an odd count, adjacent for an even one
  logic        [CW-1:0]          cnt_m1;
  logic        [IW-1:0]          lo_idx, hi_idx;
  logic signed [SAMPLE_BITS-1:0] lo, hi;
  logic signed [MW-1:0]          sum;

  assign cnt_m1 = count - CW'(1);
  assign lo_idx = IW'(cnt_m1 >> 1);
  assign hi_idx = IW'(count >> 1);

  rmt_sel #(
    .N  (MAX_SAMPLES),
    .SW (SAMPLE_BITS),
    .IW (IW)
  ) u_sel (
    .clk    (clk),
    .vals   (vals),
    .lo_idx (lo_idx),
    .hi_idx (hi_idx),
    .lo     (lo),
    .hi     (hi)
  );

  assign sum = MW'(lo) + MW'(hi);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      count         <= '0;
      last_med      <= '0;
      medians.valid <= 1'b0;
    end else begin
      // a new beat loaded in FIN replaces the one just taken
      if (medians.valid && medians.ready && !fin_go) begin
        medians.valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (acc) begin
            last_r <= samples.last_sample;
            ovf_r  <= full;
            if (!full) count <= count + CW'(1);
            state  <= SEL1;
          end
        end
        SEL1: state <= SEL2;
        SEL2: state <= FIN;
        FIN: begin
          if (fin_go) begin
            medians.valid          <= 1'b1;
            medians.median_doubled <= ovf_r ? last_med : sum;
            medians.stored_count   <= count;
            medians.overflow       <= ovf_r;
            if (last_r) begin
              count    <= '0;
              last_med <= '0;
            end else if (!ovf_r) begin
              last_med <= sum;
            end
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_SAMPLES))
    else $error("store count beyond capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    ins |=> count == $past(count) + CW'(1))
    else $error("insert did not advance count");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    medians.valid && medians.overflow |-> medians.stored_count == CW'(MAX_SAMPLES))
    else $error("overflow reported with room in store");

  a_last_clear: assert property (@(posedge clk) disable iff (rst)
    fin_go && last_r |=> count == '0 && last_med == '0)
    else $error("end of stream did not empty store");
`endif

endmodule

// ----- tb/running_median_tracker_top_tb.sv -----
`timescale 1ns / 1ps

// Checks the running median tracker against an in-bench model of the sorted
// store. The driver offers sample beats from a queue and predicts each result
// when the beat is taken. The monitor takes result beats and compares them
// with the oldest prediction.
module running_median_tracker_top_tb;
  import rmt_pkg::*;

  localparam int MAX_SAMPLES = DEF_MAX_SAMPLES;
  localparam int SAMPLE_BITS = DEF_SAMPLE_BITS;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

  // Random part size, and how many sample beats each handshake phase lasts
  localparam int unsigned RANDOM_BEATS = 1500;
  localparam int unsigned PHASE_BEATS  = 200;
  // Long receiver hold-offs start when these result counts are reached
  localparam int unsigned HOLD_AT_A    = 150;
  localparam int unsigned HOLD_AT_B    = 800;
  localparam int unsigned HOLD_CYCLES  = 200;

  // Handshake phases: free flow, sender gaps, receiver stalls, both lightly
  typedef enum int unsigned {
    PH_FREE,
    PH_TX_GAPS,
    PH_RX_STALLS,
    PH_BOTH
  } hs_phase_t;

  // How sample values are drawn within one stream
  typedef enum int unsigned {
    VAL_FULL,    // anywhere in the 16-bit range
    VAL_NARROW,  // -4..4, lots of equal samples
    VAL_EDGE     // near the most negative or most positive value
  } val_mode_t;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          is_last;
    hs_phase_t                     phase;
    bit                            drain_first;  // wait for all results first
  } sample_beat_t;

  typedef struct {
    logic signed [SAMPLE_BITS:0] median_x2;
    logic        [CNT_W-1:0]     count;
    logic                        overflow;
  } median_beat_t;

  // Per-phase odds (percent) of a sender gap and of a receiver stall
  int unsigned tx_gap_pct   [4] = '{0, 51, 0, 6};
  int unsigned rx_stall_pct [4] = '{0, 0, 51, 6};

  logic clk;
  logic rst;

  rmt_in_if  #(.SW(SAMPLE_BITS))                  samples_ch ();
  rmt_out_if #(.MW(SAMPLE_BITS + 1), .CW(CNT_W))  medians_ch ();

  running_median_tracker_top #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_ch),
    .medians (medians_ch)
  );

  sample_beat_t                  pending_samples[$];
  median_beat_t                  expected_medians[$];
  // Mirror of the block's store: ascending, last median held for overflow
  logic signed [SAMPLE_BITS-1:0] sorted_mirror[$];
  logic signed [SAMPLE_BITS+1:0] held_median_x2 = '0;

  int unsigned accepted_cnt = 0;   // written by the driver only
  int unsigned results_seen = 0;   // written by the monitor only, nonblocking
  int unsigned failures     = 0;
  int unsigned rx_hold_left = 0;
  hs_phase_t   tx_phase     = PH_FREE;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Insert one taken sample into the mirror and queue the result it causes.
  task automatic track_sample(input sample_beat_t b);
    median_beat_t                  r;
    int                            pos;
    int                            n;
    logic signed [SAMPLE_BITS+1:0] lo;
    logic signed [SAMPLE_BITS+1:0] hi;
    r.overflow = 1'b0;
    if (sorted_mirror.size() < MAX_SAMPLES) begin
      // equal samples go after the ones already held
      pos = sorted_mirror.size();
      while (pos > 0 && sorted_mirror[pos-1] > b.value)
        pos--;
      sorted_mirror.insert(pos, b.value);
      n  = sorted_mirror.size();
      hi = sorted_mirror[n/2];
      lo = (n % 2 == 1) ? hi : sorted_mirror[n/2 - 1];
      held_median_x2 = lo + hi;
    end else begin
      // store full: drop the sample, repeat the previous median
      r.overflow = 1'b1;
    end
    r.median_x2 = held_median_x2[SAMPLE_BITS:0];
    r.count     = CNT_W'(sorted_mirror.size());
    expected_medians.push_back(r);
    if (b.is_last) begin
      sorted_mirror.delete();
      held_median_x2 = '0;
    end
  endtask

  task automatic queue_sample(input logic signed [SAMPLE_BITS-1:0] v, input logic lst,
                              input hs_phase_t ph, input bit drain);
    sample_beat_t b;
    b.value       = v;
    b.is_last     = lst;
    b.phase       = ph;
    b.drain_first = drain;
    pending_samples.push_back(b);
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] draw_sample(input val_mode_t mode);
    logic signed [SAMPLE_BITS-1:0] v;
    case (mode)
      VAL_NARROW: begin
        v = SAMPLE_BITS'($urandom_range(8));
        v = v - 4;
      end
      VAL_EDGE: begin
        v = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        v = v ^ SAMPLE_BITS'($urandom_range(3));
      end
      default: v = SAMPLE_BITS'($urandom);
    endcase
    return v;
  endfunction

  // Driver: offers the head of pending_samples, predicts on each taken beat.
  // valid gets exactly one nonblocking write per edge.
  always @(posedge clk) begin
    bit offer;
    if (rst) begin
      samples_ch.valid       <= 1'b0;
      samples_ch.sample      <= '0;
      samples_ch.last_sample <= 1'b0;
    end else begin
      offer = samples_ch.valid;
      if (samples_ch.valid && samples_ch.ready) begin
        track_sample(pending_samples.pop_front());
        accepted_cnt++;
        offer = 1'b0;
      end
      if (!offer && pending_samples.size() > 0) begin
        // a drain beat waits until every result so far has come back
        if (pending_samples[0].drain_first && results_seen != accepted_cnt)
          offer = 1'b0;
        else
          offer = ($urandom_range(99) >= tx_gap_pct[pending_samples[0].phase]);
        if (offer) begin
          samples_ch.sample      <= pending_samples[0].value;
          samples_ch.last_sample <= pending_samples[0].is_last;
          tx_phase               <= pending_samples[0].phase;
        end
      end
      samples_ch.valid <= offer;
    end
  end

  // Monitor: takes result beats, compares each field with the oldest
  // prediction, and runs the long hold-offs that back the block up.
  always @(posedge clk) begin
    median_beat_t exp_r;
    if (rst) begin
      medians_ch.ready <= 1'b0;
    end else begin
      if (medians_ch.valid && medians_ch.ready) begin
        results_seen <= results_seen + 1;
        if (results_seen == HOLD_AT_A || results_seen == HOLD_AT_B)
          rx_hold_left = HOLD_CYCLES;
        if (expected_medians.size() == 0) begin
          $error("result beat with no sample pending: median_doubled %0d",
                 medians_ch.median_doubled);
          failures++;
        end else begin
          exp_r = expected_medians.pop_front();
          if (medians_ch.median_doubled !== exp_r.median_x2) begin
            $error("median_doubled expected %0d got %0d",
                   exp_r.median_x2, medians_ch.median_doubled);
            failures++;
          end
          if (medians_ch.stored_count !== exp_r.count) begin
            $error("stored_count expected %0d got %0d",
                   exp_r.count, medians_ch.stored_count);
            failures++;
          end
          if (medians_ch.overflow !== exp_r.overflow) begin
            $error("overflow expected %0d got %0d",
                   exp_r.overflow, medians_ch.overflow);
            failures++;
          end
        end
      end
      if (rx_hold_left != 0) begin
        rx_hold_left--;
        medians_ch.ready <= 1'b0;
      end else begin
        medians_ch.ready <= ($urandom_range(99) >= rx_stall_pct[tx_phase]);
      end
    end
  end

  // Stimulus: directed streams, then random streams, then wait for the tail.
  initial begin
    int unsigned random_beats;
    int unsigned stream_no;
    int unsigned len;
    val_mode_t   mode;
    hs_phase_t   ph;

    rst = 1'b1;

    // single-sample streams at both extremes and zero
    queue_sample(16'sh8000, 1'b1, PH_FREE, 1'b0);
    queue_sample(16'sh7FFF, 1'b1, PH_FREE, 1'b0);
    queue_sample(16'sh0000, 1'b1, PH_FREE, 1'b0);
    // two equal extremes: most negative and most positive doubled medians
    queue_sample(16'sh8000, 1'b0, PH_FREE, 1'b0);
    queue_sample(16'sh8000, 1'b1, PH_FREE, 1'b0);
    queue_sample(16'sh7FFF, 1'b0, PH_FREE, 1'b0);
    queue_sample(16'sh7FFF, 1'b1, PH_FREE, 1'b0);
    // opposite extremes: half value, sum is -1
    queue_sample(16'sh8000, 1'b0, PH_FREE, 1'b0);
    queue_sample(16'sh7FFF, 1'b1, PH_FREE, 1'b0);
    // equal samples
    queue_sample(16'sd5, 1'b0, PH_FREE, 1'b0);
    queue_sample(16'sd5, 1'b0, PH_FREE, 1'b0);
    queue_sample(16'sd5, 1'b1, PH_FREE, 1'b0);
    // alternating bit patterns
    queue_sample(16'sh5555, 1'b0, PH_FREE, 1'b0);
    queue_sample(16'shAAAA, 1'b1, PH_FREE, 1'b0);
    // unsorted arrival, even then odd counts
    queue_sample(16'sd3, 1'b0, PH_FREE, 1'b0);
    queue_sample(-16'sd1, 1'b0, PH_FREE, 1'b0);
    queue_sample(16'sd7, 1'b0, PH_FREE, 1'b0);
    queue_sample(16'sd2, 1'b1, PH_FREE, 1'b0);
    queue_sample(16'sd1, 1'b0, PH_FREE, 1'b0);
    queue_sample(16'sd0, 1'b0, PH_FREE, 1'b0);
    queue_sample(-16'sd1, 1'b1, PH_FREE, 1'b0);

    // Random streams. Every eighth one is long; the first two of those run
    // past the store size, so overflow and a last beat on a full store occur.
    random_beats = 0;
    stream_no    = 0;
    while (random_beats < RANDOM_BEATS) begin
      if (stream_no % 8 == 3)
        len = (stream_no < 16) ? $urandom_range(MAX_SAMPLES + 40, MAX_SAMPLES + 1)
                               : $urandom_range(MAX_SAMPLES + 40, MAX_SAMPLES - 60);
      else
        len = $urandom_range(30, 1);
      mode = val_mode_t'($urandom_range(2));
      for (int unsigned k = 0; k < len; k++) begin
        ph = hs_phase_t'((random_beats / PHASE_BEATS) % 4);
        queue_sample(draw_sample(mode), k == len - 1, ph, k == 0 && stream_no % 5 == 0);
        random_beats++;
      end
      stream_no++;
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    wait (pending_samples.size() == 0 && results_seen == accepted_cnt);
    // allow extra time for any stray beat
    repeat (20) @(posedge clk);
    if (expected_medians.size() != 0) begin
      $error("%0d predicted results never arrived", expected_medians.size());
    end
    if (failures == 0 && expected_medians.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
